/* sv/sslx_pkg.sv */
// shared types, constants and helper functions for the source lexer
// no dependencies; imported by every module of the block
package sslx_pkg;

   localparam int POSITION_BITS = 16;
   localparam int PREFIX_CHARS  = 8;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   typedef logic [POSITION_BITS-1:0] pos_type;
   typedef logic [PREFIX_CHARS-1:0][7:0] prefix_type;

   typedef enum logic [3:0] {
      MODE_IDLE     = 4'd0,
      MODE_WORD     = 4'd1,
      MODE_NUMBER   = 4'd2,
      MODE_STRING   = 4'd3,
      MODE_LINECMT  = 4'd4,
      MODE_BLOCKCMT = 4'd5,
      MODE_HASH     = 4'd6,
      MODE_CMP      = 4'd7,
      MODE_DOT      = 4'd8
   } mode_type;

   localparam logic [3:0] KIND_CMP  = 4'd0;
   localparam logic [3:0] KIND_SYM  = 4'd1;
   localparam logic [3:0] KIND_OP   = 4'd2;
   localparam logic [3:0] KIND_STR  = 4'd3;
   localparam logic [3:0] KIND_INT  = 4'd4;
   localparam logic [3:0] KIND_FLT  = 4'd5;
   localparam logic [3:0] KIND_BOOL = 4'd6;
   localparam logic [3:0] KIND_KW   = 4'd7;
   localparam logic [3:0] KIND_ID   = 4'd8;
   localparam logic [3:0] KIND_END  = 4'd9;
   localparam logic [3:0] KIND_ERR  = 4'd10;

   localparam logic [7:0] CMP_EQ = 8'd0;
   localparam logic [7:0] CMP_NE = 8'd1;
   localparam logic [7:0] CMP_GT = 8'd2;
   localparam logic [7:0] CMP_LT = 8'd3;
   localparam logic [7:0] CMP_GE = 8'd4;
   localparam logic [7:0] CMP_LE = 8'd5;

   localparam logic [7:0] KW_IF     = 8'd0;
   localparam logic [7:0] KW_ELSE   = 8'd1;
   localparam logic [7:0] KW_RETURN = 8'd2;
   localparam logic [7:0] KW_TASK   = 8'd3;
   localparam logic [7:0] KW_FOR    = 8'd4;
   localparam logic [7:0] KW_WHILE  = 8'd5;
   localparam logic [7:0] KW_BREAK  = 8'd6;
   localparam logic [7:0] KW_SKIP   = 8'd7;

   localparam logic [7:0] BOOL_FALSE = 8'd0;
   localparam logic [7:0] BOOL_TRUE  = 8'd1;

   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_HASH   = "#";
   localparam logic [7:0] CH_EQ     = "=";
   localparam logic [7:0] CH_BANG   = "!";
   localparam logic [7:0] CH_LT     = "<";
   localparam logic [7:0] CH_GT     = ">";
   localparam logic [7:0] CH_DOT    = ".";
   localparam logic [7:0] CH_DQUOTE = "\"";
   localparam logic [7:0] CH_SQUOTE = "'";
   localparam logic [7:0] CH_UNDER  = "_";

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_word_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [7:0]  token_code;
      logic [15:0] start_offset;
      logic [15:0] token_length;
      logic [15:0] token_line;
      logic        last_of_run;
   } rsp_word_type;

   // records produced by one accepted word, in order
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } step_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] code;
   } lookup_type;

   function automatic pos_type sat_inc(pos_type v);
      return (v == POS_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [15:0] clip16(pos_type v);
      logic [POSITION_BITS+15:0] wide;
      wide = {16'b0, v};
      return (wide > (POSITION_BITS + 16)'(16'hffff)) ? 16'hffff : wide[15:0];
   endfunction

   // whole-word match of the first six prefix bytes against the reserved words
   function automatic lookup_type word_lookup(prefix_type p, pos_type len);
      logic [47:0] head;
      lookup_type  r;
      for (int i = 0; i < 6; i++) begin
         head[47-8*i -: 8] = p[i];
      end
      r.kind = KIND_KW;
      r.code = 8'd0;
      if (len == POSITION_BITS'(4) && head[47:16] == "True") begin
         r.kind = KIND_BOOL;
         r.code = BOOL_TRUE;
      end else if (len == POSITION_BITS'(5) && head[47:8] == "False") begin
         r.kind = KIND_BOOL;
         r.code = BOOL_FALSE;
      end else if (len == POSITION_BITS'(2) && head[47:32] == "if") begin
         r.code = KW_IF;
      end else if (len == POSITION_BITS'(4) && head[47:16] == "else") begin
         r.code = KW_ELSE;
      end else if (len == POSITION_BITS'(6) && head == "return") begin
         r.code = KW_RETURN;
      end else if (len == POSITION_BITS'(4) && head[47:16] == "task") begin
         r.code = KW_TASK;
      end else if (len == POSITION_BITS'(3) && head[47:24] == "for") begin
         r.code = KW_FOR;
      end else if (len == POSITION_BITS'(5) && head[47:8] == "while") begin
         r.code = KW_WHILE;
      end else if (len == POSITION_BITS'(5) && head[47:8] == "break") begin
         r.code = KW_BREAK;
      end else if (len == POSITION_BITS'(4) && head[47:16] == "skip") begin
         r.code = KW_SKIP;
      end else begin
         r.kind = KIND_ID;
      end
      return r;
   endfunction

endpackage

/* sv/sslx_core.sv */
// lexer state registers and the per-byte decode that yields up to two records
// depends on sslx_pkg
module sslx_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  sslx_pkg::req_word_type req_word,
   output sslx_pkg::step_type   step
);
   import sslx_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [7:0] pending_ff, pending_in;
   prefix_type prefix_ff, prefix_in;
   pos_type    len_ff, len_in;
   pos_type    start_ff, start_in;
   pos_type    pos_ff, pos_in;
   pos_type    line_ff, line_in;
   logic       dot_ff, dot_in;

   logic [7:0] c;
   logic       eot, nl, is_hash, is_eq, is_dot, is_digit, is_alpha, is_word_ch;
   logic       is_cmp_ch, is_sym, is_op, is_quote, fall;
   lookup_type word_cls;
   rsp_word_type rec_a, rec_b;
   logic       a_valid, b_valid;

   always_comb begin
      c          = req_word.char_code;
      eot        = req_word.end_of_text;
      nl         = (c == CH_NL);
      is_hash    = (c == CH_HASH);
      is_eq      = (c == CH_EQ);
      is_dot     = (c == CH_DOT);
      is_digit   = (c >= "0") && (c <= "9");
      is_alpha   = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
      is_word_ch = is_alpha || is_digit || (c == CH_UNDER);
      is_cmp_ch  = is_eq || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
      is_sym     = (c == ";") || (c == ",") || (c == "(") || (c == ")") ||
                   (c == "{") || (c == "}") || (c == "[") || (c == "]");
      is_op      = (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "%");
      is_quote   = (c == CH_DQUOTE) || (c == CH_SQUOTE);
      word_cls   = word_lookup(prefix_ff, len_ff);
   end

   // the byte ends the current mode and is lexed again from idle
   always_comb begin
      unique case (mode_ff)
         MODE_IDLE:     fall = 1'b1;
         MODE_WORD:     fall = !is_word_ch;
         MODE_NUMBER:   fall = !(is_digit || is_dot);
         MODE_STRING:   fall = 1'b0;
         MODE_LINECMT:  fall = nl;
         MODE_BLOCKCMT: fall = 1'b0;
         MODE_HASH:     fall = 1'b0;
         MODE_CMP:      fall = !is_eq;
         MODE_DOT:      fall = !is_digit;
         default:       fall = 1'b1;
      endcase
      fall = fall && !eot;
   end

   // next state
   always_comb begin
      mode_in    = mode_ff;
      pending_in = pending_ff;
      prefix_in  = prefix_ff;
      len_in     = len_ff;
      start_in   = start_ff;
      pos_in     = pos_ff;
      line_in    = line_ff;
      dot_in     = dot_ff;
      if (fire) begin
         if (eot) begin
            mode_in = MODE_IDLE;
            pos_in  = '0;
            line_in = POSITION_BITS'(1);
         end else begin
            pos_in = sat_inc(pos_ff);
            unique case (mode_ff)
               MODE_WORD: begin
                  if (is_word_ch) begin
                     for (int i = 0; i < PREFIX_CHARS; i++) begin
                        if (len_ff == POSITION_BITS'(i)) begin
                           prefix_in[i] = c;
                        end
                     end
                     len_in = sat_inc(len_ff);
                  end
               end
               MODE_NUMBER: begin
                  if (is_digit || is_dot) begin
                     if (is_dot) begin
                        dot_in = 1'b1;
                     end
                     len_in = sat_inc(len_ff);
                  end
               end
               MODE_STRING: begin
                  if (c == pending_ff) begin
                     mode_in = MODE_IDLE;
                  end else begin
                     if (nl) begin
                        line_in = sat_inc(line_ff);
                     end
                     len_in = sat_inc(len_ff);
                  end
               end
               MODE_BLOCKCMT: begin
                  if (is_hash) begin
                     mode_in = MODE_IDLE;
                  end else if (nl) begin
                     line_in = sat_inc(line_ff);
                  end
               end
               MODE_HASH: begin
                  if (is_hash) begin
                     mode_in = MODE_LINECMT;
                  end else begin
                     mode_in = MODE_BLOCKCMT;
                     if (nl) begin
                        line_in = sat_inc(line_ff);
                     end
                  end
               end
               MODE_CMP: begin
                  if (is_eq) begin
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_DOT: begin
                  if (is_digit) begin
                     mode_in = MODE_NUMBER;
                     len_in  = POSITION_BITS'(2);
                     dot_in  = 1'b1;
                  end
               end
               default: ;
            endcase
            if (fall) begin
               mode_in = MODE_IDLE;
               priority if (nl) begin
                  line_in = sat_inc(line_ff);
               end else if (is_hash) begin
                  mode_in = MODE_HASH;
               end else if (is_cmp_ch) begin
                  mode_in    = MODE_CMP;
                  pending_in = c;
                  start_in   = pos_ff;
               end else if (is_quote) begin
                  mode_in    = MODE_STRING;
                  pending_in = c;
                  start_in   = sat_inc(pos_ff);
                  len_in     = '0;
               end else if (is_digit) begin
                  mode_in  = MODE_NUMBER;
                  start_in = pos_ff;
                  len_in   = POSITION_BITS'(1);
                  dot_in   = 1'b0;
               end else if (is_dot) begin
                  mode_in  = MODE_DOT;
                  start_in = pos_ff;
               end else if (is_alpha) begin
                  mode_in      = MODE_WORD;
                  start_in     = pos_ff;
                  len_in       = POSITION_BITS'(1);
                  prefix_in    = '0;
                  prefix_in[0] = c;
               end else begin
                  mode_in = MODE_IDLE;
               end
            end
         end
      end
   end

   // records: rec_a flushes the pending token, rec_b comes from the byte itself or end mark
   always_comb begin
      rec_a   = '0;
      rec_b   = '0;
      a_valid = 1'b0;
      b_valid = 1'b0;
      rec_a.token_line   = clip16(line_ff);
      rec_b.token_line   = clip16(line_ff);
      rec_a.start_offset = clip16(start_ff);
      rec_a.token_length = clip16(len_ff);
      if (fire) begin
         unique case (mode_ff)
            MODE_WORD: begin
               if (eot || !is_word_ch) begin
                  a_valid          = 1'b1;
                  rec_a.token_kind = word_cls.kind;
                  rec_a.token_code = word_cls.code;
               end
            end
            MODE_NUMBER: begin
               if (eot || !(is_digit || is_dot)) begin
                  a_valid          = 1'b1;
                  rec_a.token_kind = dot_ff ? KIND_FLT : KIND_INT;
               end
            end
            MODE_STRING: begin
               if (eot) begin
                  a_valid          = 1'b1;
                  rec_a.token_kind = KIND_ERR;
               end else if (c == pending_ff) begin
                  a_valid          = 1'b1;
                  rec_a.token_kind = KIND_STR;
               end
            end
            MODE_CMP: begin
               if (!eot && is_eq) begin
                  a_valid            = 1'b1;
                  rec_a.token_kind   = KIND_CMP;
                  rec_a.token_length = 16'd2;
                  priority if (pending_ff == CH_EQ) begin
                     rec_a.token_code = CMP_EQ;
                  end else if (pending_ff == CH_BANG) begin
                     rec_a.token_code = CMP_NE;
                  end else if (pending_ff == CH_GT) begin
                     rec_a.token_code = CMP_GE;
                  end else begin
                     rec_a.token_code = CMP_LE;
                  end
               end else begin
                  // single comparator byte; a lone bang gives nothing
                  rec_a.token_length = 16'd1;
                  priority if (pending_ff == CH_EQ) begin
                     a_valid          = 1'b1;
                     rec_a.token_kind = KIND_OP;
                     rec_a.token_code = CH_EQ;
                  end else if (pending_ff == CH_GT) begin
                     a_valid          = 1'b1;
                     rec_a.token_kind = KIND_CMP;
                     rec_a.token_code = CMP_GT;
                  end else if (pending_ff == CH_LT) begin
                     a_valid          = 1'b1;
                     rec_a.token_kind = KIND_CMP;
                     rec_a.token_code = CMP_LT;
                  end else begin
                     a_valid = 1'b0;
                  end
               end
            end
            default: ;
         endcase
         if (eot) begin
            b_valid            = 1'b1;
            rec_b.token_kind   = KIND_END;
            rec_b.start_offset = clip16(pos_ff);
         end else if (fall && (is_sym || is_op)) begin
            b_valid            = 1'b1;
            rec_b.token_kind   = is_sym ? KIND_SYM : KIND_OP;
            rec_b.token_code   = c;
            rec_b.start_offset = clip16(pos_ff);
            rec_b.token_length = 16'd1;
         end
      end
   end

   always_comb begin
      step = '0;
      if (a_valid && b_valid) begin
         step.count              = 2'd2;
         step.first              = rec_a;
         step.second             = rec_b;
         step.second.last_of_run = 1'b1;
      end else if (a_valid) begin
         step.count             = 2'd1;
         step.first             = rec_a;
         step.first.last_of_run = 1'b1;
      end else if (b_valid) begin
         step.count             = 2'd1;
         step.first             = rec_b;
         step.first.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         pending_ff <= '0;
         prefix_ff  <= '0;
         len_ff     <= '0;
         start_ff   <= '0;
         pos_ff     <= '0;
         line_ff    <= POSITION_BITS'(1);
         dot_ff     <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         pending_ff <= pending_in;
         prefix_ff  <= prefix_in;
         len_ff     <= len_in;
         start_ff   <= start_in;
         pos_ff     <= pos_in;
         line_ff    <= line_in;
         dot_ff     <= dot_in;
      end
   end

endmodule

/* sv/sslx_outq.sv */
// small result queue taking up to two records a cycle and giving one while rsp_ready is high
// depends on sslx_pkg
module sslx_outq (
   input  logic                   clock,
   input  logic                   reset,
   input  sslx_pkg::step_type     step,
   output logic                   space,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sslx_pkg::rsp_word_type rsp_word
);
   import sslx_pkg::*;

   rsp_word_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]         wr_ff, wr_in, rd_ff, rd_in, wr_next;
   logic [QCNT_W-1:0]         cnt_ff, cnt_in;
   logic                      pop;

   always_comb begin
      pop       = rsp_valid && rsp_ready;
      wr_next   = wr_ff + 1'b1;
      wr_in     = wr_ff + QPTR_W'(step.count);
      rd_in     = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in    = cnt_ff + QCNT_W'(step.count) - QCNT_W'(pop);
      // room for a word that gives two records
      space     = (cnt_ff <= QCNT_W'(QUEUE_DEPTH - 2));
      rsp_valid = (cnt_ff != '0);
      rsp_word  = entry_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (step.count != 2'd0) begin
         entry_ff[wr_ff] <= step.first;
      end
      if (step.count == 2'd2) begin
         entry_ff[wr_next] <= step.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* sv/script_source_lexer_unit.sv */
// Source lexer: takes one source byte (or end-of-text mark) per word and emits
// token records. One byte is accepted every cycle while req_ready is high; each
// byte yields zero, one or two records, which drain one per cycle while rsp_ready
// is high through a four-entry queue; req_ready drops only while that queue holds
// more than two records (long runs of two-record bytes or a stalled result side).
// Each record is registered in the queue before it leaves. Reset is synchronous.
// depends on sslx_pkg, sslx_core and sslx_outq
module script_source_lexer_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sslx_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sslx_pkg::rsp_word_type rsp_word
);
   import sslx_pkg::*;

   step_type step;
   logic     space;
   logic     fire;

   assign req_ready = space;
   assign fire      = req_valid && space;

   sslx_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req_word (req_word),
      .step     (step)
   );

   sslx_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

/* tb/sv/script_source_lexer_unit_test.sv */
// self-checking bench for the source lexer: random and directed source text,
// each accepted word run through a lexer predictor, records compared in order
// depends on sslx_pkg and script_source_lexer_unit
module script_source_lexer_unit_test;
   import sslx_pkg::*;

   typedef struct packed {
      req_word_type word;
      logic         quick;
   } pending_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   pending_type  pending_words [$];
   rsp_word_type expected_tokens [$];
   rsp_word_type step_tokens [$];
   pending_type  next_word;

   bit  req_fired = 1'b0;
   bit  rsp_fired = 1'b0;
   bit  rsp_hold = 1'b0;
   bit  quick_mode = 1'b0;
   int  send_gap = 0;
   int  rsp_wait = 0;
   int  calm_left = 0;
   int  sent_count = 0;
   int  ends_sent = 0;
   int  checked_count = 0;
   int  error_count = 0;

   // lexer predictor state
   mode_type    lx_mode;
   logic [7:0]  lx_quote;
   logic [7:0]  lx_head [8];
   logic [15:0] lx_len;
   logic [15:0] lx_start;
   logic [15:0] lx_pos;
   logic [15:0] lx_line;
   bit          lx_dot;

   string       keyword_names [8] = '{"if", "else", "return", "task", "for", "while",
                                      "break", "skip"};
   logic [7:0]  keyword_codes [8] = '{KW_IF, KW_ELSE, KW_RETURN, KW_TASK, KW_FOR, KW_WHILE,
                                      KW_BREAK, KW_SKIP};
   string       reserved_names [10] = '{"if", "else", "return", "task", "for", "while",
                                        "break", "skip", "True", "False"};
   string       comparator_texts [8] = '{"==", "!=", "<=", ">=", "<", ">", "=", "!"};
   string       letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
   string       word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
   string       symbol_chars = ";,(){}[]";
   string       operator_chars = "+-*/%";

   script_source_lexer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
   end

   // ---------------- predictor ----------------

   function automatic logic [15:0] bump(logic [15:0] v);
      return (v == 16'hffff) ? v : v + 16'd1;
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit in_set(logic [7:0] c, string s);
      for (int i = 0; i < s.len(); i++) begin
         if (c == s[i]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit head_is(string w);
      if (lx_len != 16'(w.len())) return 1'b0;
      for (int i = 0; i < w.len(); i++) begin
         if (lx_head[i] != w[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic lexer_reset();
      lx_mode = MODE_IDLE;
      lx_quote = 8'd0;
      foreach (lx_head[i]) lx_head[i] = 8'd0;
      lx_len = 16'd0;
      lx_start = 16'd0;
      lx_pos = 16'd0;
      lx_line = 16'd1;
      lx_dot = 1'b0;
   endtask

   task automatic add_token(logic [3:0] kind, logic [7:0] code, logic [15:0] start,
                            logic [15:0] len);
      rsp_word_type rec;
      if (step_tokens.size() >= 2) return;
      rec.token_kind = kind;
      rec.token_code = code;
      rec.start_offset = start;
      rec.token_length = len;
      rec.token_line = lx_line;
      rec.last_of_run = 1'b0;
      step_tokens.push_back(rec);
   endtask

   task automatic emit_word_token();
      bit found;
      found = 1'b0;
      if (head_is("True")) begin
         add_token(KIND_BOOL, BOOL_TRUE, lx_start, lx_len);
      end else if (head_is("False")) begin
         add_token(KIND_BOOL, BOOL_FALSE, lx_start, lx_len);
      end else begin
         for (int k = 0; k < 8; k++) begin
            if (!found && head_is(keyword_names[k])) begin
               add_token(KIND_KW, keyword_codes[k], lx_start, lx_len);
               found = 1'b1;
            end
         end
         if (!found) add_token(KIND_ID, 8'd0, lx_start, lx_len);
      end
   endtask

   task automatic emit_single_cmp();
      if (lx_quote == CH_EQ) add_token(KIND_OP, CH_EQ, lx_start, 16'd1);
      else if (lx_quote == CH_GT) add_token(KIND_CMP, CMP_GT, lx_start, 16'd1);
      else if (lx_quote == CH_LT) add_token(KIND_CMP, CMP_LT, lx_start, 16'd1);
   endtask

   task automatic lex_idle(logic [7:0] c, logic [15:0] p);
      if (c == CH_NL) begin
         lx_line = bump(lx_line);
      end else if (c == CH_HASH) begin
         lx_mode = MODE_HASH;
      end else if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT) begin
         lx_mode = MODE_CMP;
         lx_quote = c;
         lx_start = p;
      end else if (in_set(c, symbol_chars)) begin
         add_token(KIND_SYM, c, p, 16'd1);
      end else if (in_set(c, operator_chars)) begin
         add_token(KIND_OP, c, p, 16'd1);
      end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
         lx_mode = MODE_STRING;
         lx_quote = c;
         lx_start = bump(p);
         lx_len = 16'd0;
      end else if (is_digit(c)) begin
         lx_mode = MODE_NUMBER;
         lx_start = p;
         lx_len = 16'd1;
         lx_dot = 1'b0;
      end else if (c == CH_DOT) begin
         lx_mode = MODE_DOT;
         lx_start = p;
      end else if (is_alpha(c)) begin
         lx_mode = MODE_WORD;
         lx_start = p;
         lx_len = 16'd1;
         foreach (lx_head[i]) lx_head[i] = 8'd0;
         lx_head[0] = c;
      end
   endtask

   task automatic lex_byte(logic [7:0] c, logic [15:0] p);
      bit restart;
      logic [7:0] code;
      restart = 1'b1;
      case (lx_mode)
         MODE_WORD: begin
            if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
               if (lx_len < 16'd8) lx_head[lx_len[2:0]] = c;
               lx_len = bump(lx_len);
               restart = 1'b0;
            end else begin
               emit_word_token();
            end
         end
         MODE_NUMBER: begin
            if (is_digit(c) || c == CH_DOT) begin
               if (c == CH_DOT) lx_dot = 1'b1;
               lx_len = bump(lx_len);
               restart = 1'b0;
            end else begin
               add_token(lx_dot ? KIND_FLT : KIND_INT, 8'd0, lx_start, lx_len);
            end
         end
         MODE_STRING: begin
            restart = 1'b0;
            if (c == lx_quote) begin
               add_token(KIND_STR, 8'd0, lx_start, lx_len);
               lx_mode = MODE_IDLE;
            end else begin
               if (c == CH_NL) lx_line = bump(lx_line);
               lx_len = bump(lx_len);
            end
         end
         MODE_LINECMT: begin
            if (c != CH_NL) restart = 1'b0;
         end
         MODE_BLOCKCMT: begin
            restart = 1'b0;
            if (c == CH_HASH) lx_mode = MODE_IDLE;
            else if (c == CH_NL) lx_line = bump(lx_line);
         end
         MODE_HASH: begin
            restart = 1'b0;
            if (c == CH_HASH) begin
               lx_mode = MODE_LINECMT;
            end else begin
               lx_mode = MODE_BLOCKCMT;
               if (c == CH_NL) lx_line = bump(lx_line);
            end
         end
         MODE_CMP: begin
            if (c == CH_EQ) begin
               code = (lx_quote == CH_EQ) ? CMP_EQ : (lx_quote == CH_BANG) ? CMP_NE :
                      (lx_quote == CH_GT) ? CMP_GE : CMP_LE;
               add_token(KIND_CMP, code, lx_start, 16'd2);
               lx_mode = MODE_IDLE;
               restart = 1'b0;
            end else begin
               emit_single_cmp();
            end
         end
         MODE_DOT: begin
            if (is_digit(c)) begin
               lx_mode = MODE_NUMBER;
               lx_len = 16'd2;
               lx_dot = 1'b1;
               restart = 1'b0;
            end
         end
         default: ;
      endcase
      if (restart) begin
         lx_mode = MODE_IDLE;
         lex_idle(c, p);
      end
   endtask

   task automatic lex_end();
      case (lx_mode)
         MODE_WORD:   emit_word_token();
         MODE_NUMBER: add_token(lx_dot ? KIND_FLT : KIND_INT, 8'd0, lx_start, lx_len);
         MODE_STRING: add_token(KIND_ERR, 8'd0, lx_start, lx_len);
         MODE_CMP:    emit_single_cmp();
         default: ;
      endcase
      add_token(KIND_END, 8'd0, lx_pos, 16'd0);
      lx_mode = MODE_IDLE;
      lx_pos = 16'd0;
      lx_line = 16'd1;
   endtask

   task automatic predict_tokens(req_word_type w);
      logic [15:0] p;
      step_tokens.delete();
      if (w.end_of_text) begin
         lex_end();
      end else begin
         p = lx_pos;
         lx_pos = bump(lx_pos);
         lex_byte(w.char_code, p);
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endtask

   // ---------------- checking ----------------

   task automatic report_mismatch(string field, logic [15:0] got_v, logic [15:0] want_v);
      $display("record %0d %s: got %0d, expected %0d", checked_count, field, got_v, want_v);
      error_count++;
   endtask

   task automatic check_token(rsp_word_type got);
      rsp_word_type want;
      if (expected_tokens.size() == 0) begin
         report_mismatch("arrived with nothing expected, kind", 16'(got.token_kind), 16'd0);
         return;
      end
      want = expected_tokens.pop_front();
      checked_count++;
      if (got.token_kind !== want.token_kind)
         report_mismatch("kind", 16'(got.token_kind), 16'(want.token_kind));
      if (got.token_code !== want.token_code)
         report_mismatch("code", 16'(got.token_code), 16'(want.token_code));
      if (got.start_offset !== want.start_offset)
         report_mismatch("start", got.start_offset, want.start_offset);
      if (got.token_length !== want.token_length)
         report_mismatch("length", got.token_length, want.token_length);
      if (got.token_line !== want.token_line)
         report_mismatch("line", got.token_line, want.token_line);
      if (got.last_of_run !== want.last_of_run)
         report_mismatch("last", 16'(got.last_of_run), 16'(want.last_of_run));
   endtask

   always @(posedge clock) begin
      req_fired = !reset && req_valid && req_ready;
      rsp_fired = !reset && rsp_valid && rsp_ready;
      if (reset) lexer_reset();
      if (req_fired) predict_tokens(req_word);
      if (rsp_fired) check_token(rsp_word);
   end

   // ---------------- driver and receiver ----------------

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_word <= '0;
      end else if (!req_valid || req_fired) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            next_word = pending_words.pop_front();
            req_word <= next_word.word;
            req_valid <= 1'b1;
            send_gap = next_word.quick ? 0 : $urandom_range(0, 11);
            sent_count++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_fired) begin
            if (calm_left > 0) begin
               calm_left--;
               rsp_wait = 0;
            end else begin
               rsp_wait = $urandom_range(0, 11);
               if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 40);
            end
         end
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // long result-side stalls so the output queue fills and input backs up
   initial begin
      wait (sent_count >= 300);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold = 1'b0;
      wait (sent_count >= 900);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (200) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // ---------------- stimulus ----------------

   task automatic put_word(logic [7:0] c, logic eot);
      pending_type item;
      item.word.char_code = c;
      item.word.end_of_text = eot;
      item.quick = quick_mode;
      pending_words.push_back(item);
   endtask

   task automatic put_byte(logic [7:0] c);
      put_word(c, 1'b0);
   endtask

   task automatic put_filler(logic [7:0] c);
      put_word(c, 1'b0);
   endtask

   task automatic put_end();
      put_word(8'($urandom_range(0, 255)), 1'b1);
      ends_sent++;
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   task automatic put_fragment();
      int n;
      int pick;
      logic [7:0] q;
      logic [7:0] c;
      string w;
      case ($urandom_range(0, 14))
         0: put_text(keyword_names[$urandom_range(0, 7)]);
         1: put_text($urandom_range(0, 1) ? "True" : "False");
         2: begin
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
               // reserved word cut short
               w = reserved_names[$urandom_range(0, 9)];
               put_text(w.substr(0, w.len() - 2));
            end else if (pick == 1) begin
               // reserved word running on into a longer name
               put_text(reserved_names[$urandom_range(0, 9)]);
               put_byte(rand_pick(word_chars));
            end else begin
               put_byte(rand_pick(letters));
               n = $urandom_range(0, 11);
               repeat (n) put_byte(rand_pick(word_chars));
            end
         end
         3: begin
            n = $urandom_range(1, 6);
            repeat (n) put_byte(rand_digit());
         end
         4: begin
            n = $urandom_range(1, 3);
            repeat (n) put_byte(rand_digit());
            put_byte(CH_DOT);
            n = $urandom_range(0, 3);
            repeat (n) put_byte(rand_digit());
            if ($urandom_range(0, 3) == 0) put_byte(CH_DOT);
         end
         5: begin
            put_byte(CH_DOT);
            if ($urandom_range(0, 1)) begin
               n = $urandom_range(1, 3);
               repeat (n) put_byte(rand_digit());
            end
         end
         6: begin
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            put_byte(q);
            n = $urandom_range(0, 8);
            repeat (n) begin
               c = ($urandom_range(0, 7) == 0) ? CH_NL : 8'($urandom_range(32, 126));
               if (c == q) c = "a";
               put_byte(c);
            end
            if ($urandom_range(0, 5) != 0) put_byte(q);
         end
         7: put_text(comparator_texts[$urandom_range(0, 7)]);
         8: put_byte(rand_pick(symbol_chars));
         9: put_byte(rand_pick(operator_chars));
         10: begin
            put_text("##");
            n = $urandom_range(0, 8);
            repeat (n) put_byte(8'($urandom_range(32, 126)));
            put_byte(CH_NL);
         end
         11: begin
            put_byte(CH_HASH);
            n = $urandom_range(1, 8);
            repeat (n) begin
               c = ($urandom_range(0, 5) == 0) ? CH_NL : 8'($urandom_range(32, 126));
               if (c == CH_HASH) c = "z";
               put_byte(c);
            end
            put_byte(CH_HASH);
         end
         12: put_byte(CH_NL);
         13: put_filler(8'($urandom_range(0, 255)));
         default: begin
            if ($urandom_range(0, 2) == 0) put_end();
            else put_filler(" ");
         end
      endcase
      case ($urandom_range(0, 3))
         1: put_filler(" ");
         2: put_byte(CH_NL);
         3: put_filler(8'h09);
         default: ;
      endcase
   endtask

   initial begin
      // directed: a boolean, two-byte and single comparators, dot then digit,
      // dropped bang, lone equals flushed at end of text
      put_text("False<=.5!a=");
      put_end();
      // open string with a newline inside
      put_text("'s\n");
      put_end();
      // unknown bytes, line and block comments across newlines, multi-dot number
      put_byte(8'hff);
      put_byte(8'h00);
      put_text("##\n#\n#;9.1.");
      put_end();

      while (pending_words.size() < 1250) begin
         if ($urandom_range(0, 39) == 0) quick_mode = !quick_mode;
         put_fragment();
      end
      put_end();

      wait (pending_words.size() == 0 && !req_valid);
      wait (expected_tokens.size() == 0);
      repeat (20) @(posedge clock);
      $display("sent %0d words over %0d texts, checked %0d token records",
               sent_count, ends_sent, checked_count);
      if (error_count == 0) begin
         $display("script_source_lexer_unit_test passed");
      end else begin
         $display("script_source_lexer_unit_test failed");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("timed out with %0d records outstanding", expected_tokens.size());
      $display("script_source_lexer_unit_test failed");
      $finish;
   end

endmodule
